FILE: rtl/core/rsq_pkg.sv
// ----------------------------------------------------------------------------
// rsq_pkg
// Shared widths, constants, codes and types of the rank-select scale quantizer.
// ----------------------------------------------------------------------------
`default_nettype none

package rsq_pkg;

   // tone set
   localparam int TONE_COUNT = 60;
   localparam int TONE_IDX_W = $clog2(TONE_COUNT);
   localparam int COUNT_W    = $clog2(TONE_COUNT + 1);
   localparam int TONE_OFS   = 24;

   // field widths
   localparam int COIN_W     = 60;
   localparam int CV_W       = 15;
   localparam int BUTTON_W   = 6;
   localparam int SIGNAL_W   = 15;
   localparam int BASE_W     = 4;
   localparam int PITCH_W    = 7;
   localparam int ACTIVE_W   = 6;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 2;

   localparam int BASE_MAX   = 11;
   localparam int ACTIVE_MAX = 2**ACTIVE_W - 1;
   localparam int FIN_W      = 7;
   localparam int LAST_RESET = 60;

   // cv toggle index: trunc(mv*12/1000), divide by 1000 as reciprocal multiply
   localparam int CV_MAG_W   = CV_W + 1;
   localparam int CV_X_W     = CV_MAG_W + 2;
   localparam int CV_RECIP_W = 19;
   localparam logic [CV_RECIP_W-1:0] CV_RECIP = 19'd268436;
   localparam int CV_SHIFT   = 28;
   localparam int CV_PROD_W  = CV_X_W + CV_RECIP_W;
   localparam int CV_Q_W     = CV_PROD_W - CV_SHIFT;
   localparam int CV_IDX_W   = CV_Q_W + 1;

   // selection level in mV
   localparam int LEVEL_W     = 14;
   localparam int LEVEL_MAX   = 10000;
   localparam int BIPOLAR_OFS = 5000;

   // rank = count*level/10000 as reciprocal multiply
   localparam int RANK_PROD_W = COUNT_W + LEVEL_W;
   localparam int SEL_RECIP_W = 19;
   localparam logic [SEL_RECIP_W-1:0] SEL_RECIP = 19'd429497;
   localparam int SEL_SHIFT   = 32;
   localparam int RANK_FULL_W = RANK_PROD_W + SEL_RECIP_W;

   // serial scan over the tone mask, one digit a cycle
   localparam int DIGIT_W    = 2;
   localparam int SCAN_STEPS = (TONE_COUNT + DIGIT_W - 1) / DIGIT_W;
   localparam int SCAN_W     = SCAN_STEPS * DIGIT_W;
   localparam int STEP_W     = $clog2(SCAN_STEPS);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_RANGE_MODE    = 2'd0,
      CSR_BIPOLAR       = 2'd1,
      CSR_SUBSET_TOGGLE = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      RANGE_ALL     = 2'd0,
      RANGE_INNER12 = 2'd1,
      RANGE_INNER24 = 2'd2
   } range_mode_type;

   typedef enum logic [2:0] {
      CTL_IDLE,
      CTL_EVENT,
      CTL_TOGGLE,
      CTL_START,
      CTL_SCAN,
      CTL_RESULT
   } ctl_state_type;

   typedef enum logic [2:0] {
      SCN_IDLE,
      SCN_COUNT,
      SCN_PRODUCT,
      SCN_RANK,
      SCN_SELECT,
      SCN_DONE
   } scan_state_type;

   typedef struct packed {
      logic event_go;
      logic toggle_go;
      logic reset_event;
      logic random_event;
      logic cv_toggle_event;
      logic button_event;
   } mask_cmd_type;

   typedef struct packed {
      logic                  done;
      logic                  note_valid;
      logic [TONE_IDX_W-1:0] sel;
      logic [COUNT_W-1:0]    count;
   } scan_result_type;

   typedef struct packed {
      logic                       reset_event;
      logic                       random_event;
      logic [COIN_W-1:0]          coin_mask;
      logic                       cv_toggle_event;
      logic signed [CV_W-1:0]     tone_cv_mv;
      logic                       button_event;
      logic [BUTTON_W-1:0]        button_index;
      logic                       signal_connected;
      logic signed [SIGNAL_W-1:0] signal_mv;
      logic [BASE_W-1:0]          base_tone;
   } req_word_type;

   // octave window of the range mode; mode three behaves as mode two
   function automatic logic [TONE_COUNT-1:0] window_mask(input logic [1:0] mode);
      logic [TONE_COUNT-1:0] m;
      int lo;
      int hi;
      unique case (range_mode_type'(mode))
         RANGE_ALL: begin
            lo = 0;
            hi = TONE_COUNT - 1;
         end
         RANGE_INNER12: begin
            lo = 12;
            hi = TONE_COUNT - 13;
         end
         default: begin
            lo = 24;
            hi = TONE_COUNT - 25;
         end
      endcase
      for (int i = 0; i < TONE_COUNT; i++) begin
         m[i] = (i >= lo) && (i <= hi);
      end
      return m;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/core/rsq_if.sv
// ----------------------------------------------------------------------------
// rsq_if
// Valid/ready channels of the quantizer: request words and response words.
// ----------------------------------------------------------------------------
`default_nettype none

interface rsq_req_if import rsq_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic                       reset_event;
   logic                       random_event;
   logic [COIN_W-1:0]          coin_mask;
   logic                       cv_toggle_event;
   logic signed [CV_W-1:0]     tone_cv_mv;
   logic                       button_event;
   logic [BUTTON_W-1:0]        button_index;
   logic                       signal_connected;
   logic signed [SIGNAL_W-1:0] signal_mv;
   logic [BASE_W-1:0]          base_tone;

   modport source (
      output valid, reset_event, random_event, coin_mask, cv_toggle_event, tone_cv_mv,
             button_event, button_index, signal_connected, signal_mv, base_tone,
      input  ready
   );
   modport sink (
      input  valid, reset_event, random_event, coin_mask, cv_toggle_event, tone_cv_mv,
             button_event, button_index, signal_connected, signal_mv, base_tone,
      output ready
   );
endinterface

interface rsq_rsp_if import rsq_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic                      note_valid;
   logic signed [PITCH_W-1:0] pitch_semitones;
   logic                      tone_changed;
   logic [ACTIVE_W-1:0]       active_count;

   modport source (
      output valid, note_valid, pitch_semitones, tone_changed, active_count,
      input  ready
   );
   modport sink (
      input  valid, note_valid, pitch_semitones, tone_changed, active_count,
      output ready
   );
endinterface

`default_nettype wire

FILE: rtl/core/rsq_mask_unit.sv
// ----------------------------------------------------------------------------
// rsq_mask_unit
// Tone and candidate masks: clear, random subset pass, cv and button toggles.
// ----------------------------------------------------------------------------
`default_nettype none

module rsq_mask_unit import rsq_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  mask_cmd_type           cmd,
   input  logic                   subset_toggle,
   input  logic [COIN_W-1:0]      coin_mask,
   input  logic signed [CV_W-1:0] tone_cv_mv,
   input  logic [BUTTON_W-1:0]    button_index,
   output logic [TONE_COUNT-1:0]  tone_on
);

   logic [TONE_COUNT-1:0] tone_on_ff, tone_on_in;
   logic [TONE_COUNT-1:0] cand_ff, cand_in;
   logic [CV_PROD_W-1:0]  cv_prod_ff, cv_prod_in;
   logic                  cv_neg_ff, cv_neg_in;

   logic [TONE_COUNT-1:0] on_a, cand_a, pool, on_b, pool_b, coins, pick, cand_b, lowest;
   logic [TONE_COUNT-1:0] rnd_on, rnd_cand;
   logic signed [CV_MAG_W-1:0] mv_ext;
   logic [CV_MAG_W-1:0]   mv_mag;
   logic [CV_X_W-1:0]     cv_x;
   logic [CV_Q_W-1:0]     cv_q;
   logic signed [CV_IDX_W-1:0] cv_idx;
   logic                  cv_hit, bt_hit;
   logic [TONE_COUNT-1:0] cv_bit, bt_bit;

   // clear and random subset
   always_comb begin
      on_a   = cmd.reset_event ? '0 : tone_on_ff;
      cand_a = cmd.reset_event ? '0 : cand_ff;
      pool   = on_a | cand_a;
      if (pool == '0) begin
         on_b   = '0;
         pool_b = '1;
      end else begin
         on_b   = on_a;
         pool_b = pool;
      end
      coins  = TONE_COUNT'(coin_mask);
      pick   = subset_toggle ? ((on_b ^ coins) & pool_b) : (coins & pool_b);
      cand_b = pool_b & ~pick;
      lowest = cand_b & (~cand_b + TONE_COUNT'(1));
      if (pick == '0) begin
         pick   = lowest;
         cand_b = cand_b & ~lowest;
      end
      rnd_on   = cmd.random_event ? pick   : on_a;
      rnd_cand = cmd.random_event ? cand_b : cand_a;
   end

   // cv magnitude times 12 times the reciprocal of 1000
   always_comb begin
      mv_ext     = CV_MAG_W'(tone_cv_mv);
      mv_mag     = mv_ext[CV_MAG_W-1] ? CV_MAG_W'(-mv_ext) : CV_MAG_W'(mv_ext);
      cv_x       = CV_X_W'({mv_mag, 3'b000}) + CV_X_W'({mv_mag, 2'b00});
      cv_prod_in = cv_x * CV_RECIP;
      cv_neg_in  = mv_ext[CV_MAG_W-1];
   end

   // toggles; two hits on one tone cancel
   always_comb begin
      cv_q   = cv_prod_ff[CV_PROD_W-1:CV_SHIFT];
      cv_idx = cv_neg_ff ? (CV_IDX_W'(TONE_OFS) - CV_IDX_W'(cv_q))
                         : (CV_IDX_W'(TONE_OFS) + CV_IDX_W'(cv_q));
      cv_hit = cmd.cv_toggle_event && !cv_idx[CV_IDX_W-1] &&
               ($unsigned(cv_idx) < CV_IDX_W'(TONE_COUNT));
      bt_hit = cmd.button_event &&
               ((BUTTON_W+1)'(button_index) < (BUTTON_W+1)'(TONE_COUNT));
      cv_bit = cv_hit ? (TONE_COUNT'(1) << cv_idx[TONE_IDX_W-1:0]) : '0;
      bt_bit = bt_hit ? (TONE_COUNT'(1) << TONE_IDX_W'(button_index)) : '0;
   end

   always_comb begin
      tone_on_in = tone_on_ff;
      cand_in    = cand_ff;
      if (cmd.event_go) begin
         tone_on_in = rnd_on;
         cand_in    = rnd_cand;
      end else if (cmd.toggle_go) begin
         tone_on_in = tone_on_ff ^ cv_bit ^ bt_bit;
         cand_in    = cand_ff & ~(cv_bit | bt_bit);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tone_on_ff <= '0;
         cand_ff    <= '0;
      end else begin
         tone_on_ff <= tone_on_in;
         cand_ff    <= cand_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.event_go) begin
         cv_prod_ff <= cv_prod_in;
         cv_neg_ff  <= cv_neg_in;
      end
   end

   assign tone_on = tone_on_ff;

endmodule

`default_nettype wire

FILE: rtl/core/rsq_rank_scan.sv
// ----------------------------------------------------------------------------
// rsq_rank_scan
// Digit-serial count of the active tones, rank from the level, then a second
// digit-serial pass that finds the tone of that rank.
// ----------------------------------------------------------------------------
`default_nettype none

module rsq_rank_scan import rsq_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [TONE_COUNT-1:0] act,
   input  logic                  signal_connected,
   input  logic [LEVEL_W-1:0]    level,
   output scan_result_type       result
);

   scan_state_type state_ff, state_in;

   logic [SCAN_W-1:0]      shift_ff;
   logic [STEP_W-1:0]      step_ff;
   logic [COUNT_W-1:0]     count_ff, count_in;
   logic [RANK_PROD_W-1:0] prod_ff;
   logic [COUNT_W-1:0]     rank_ff, rank_in;
   logic [TONE_IDX_W-1:0]  sel_ff, sel_in;
   logic                   found_ff, found_in;

   logic [RANK_FULL_W-1:0] rank_full;
   logic [COUNT_W-1:0]     rank_raw;
   logic [COUNT_W-1:0]     rank_step;
   logic                   last_step;
   logic                   do_load, do_count, do_product, do_rank, do_select;

   assign last_step = (step_ff == STEP_W'(SCAN_STEPS - 1));

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         SCN_IDLE:    if (start) state_in = SCN_COUNT;
         SCN_COUNT:   if (last_step) state_in = SCN_PRODUCT;
         SCN_PRODUCT: state_in = SCN_RANK;
         SCN_RANK: begin
            if (signal_connected && (count_ff != '0)) state_in = SCN_SELECT;
            else state_in = SCN_DONE;
         end
         SCN_SELECT:  if (found_in || last_step) state_in = SCN_DONE;
         SCN_DONE:    state_in = SCN_IDLE;
         default:     state_in = SCN_IDLE;
      endcase
   end

   // controls
   always_comb begin
      do_load    = 1'b0;
      do_count   = 1'b0;
      do_product = 1'b0;
      do_rank    = 1'b0;
      do_select  = 1'b0;
      unique case (state_ff)
         SCN_IDLE:    do_load    = start;
         SCN_COUNT:   do_count   = 1'b1;
         SCN_PRODUCT: do_product = 1'b1;
         SCN_RANK:    do_rank    = 1'b1;
         SCN_SELECT:  do_select  = 1'b1;
         SCN_DONE:    ;
         default:     ;
      endcase
   end

   always_comb begin
      count_in = count_ff;
      for (int j = 0; j < DIGIT_W; j++) begin
         count_in = count_in + COUNT_W'(shift_ff[j]);
      end
   end

   // rank = floor(count*level/10000), held below count
   always_comb begin
      rank_full = RANK_FULL_W'(prod_ff) * RANK_FULL_W'(SEL_RECIP);
      rank_raw  = COUNT_W'(rank_full >> SEL_SHIFT);
      rank_in   = (rank_raw >= count_ff) ? (count_ff - COUNT_W'(1)) : rank_raw;
   end

   // walk the digit, counting down the rank on each set bit
   always_comb begin
      found_in  = found_ff;
      sel_in    = sel_ff;
      rank_step = rank_ff;
      for (int j = 0; j < DIGIT_W; j++) begin
         if (!found_in && shift_ff[j]) begin
            if (rank_step == '0) begin
               found_in = 1'b1;
               sel_in   = TONE_IDX_W'(int'(step_ff) * DIGIT_W + j);
            end else begin
               rank_step = rank_step - COUNT_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SCN_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_load) begin
         shift_ff <= SCAN_W'(act);
         step_ff  <= '0;
         count_ff <= '0;
      end else if (do_count) begin
         shift_ff <= shift_ff >> DIGIT_W;
         step_ff  <= step_ff + STEP_W'(1);
         count_ff <= count_in;
      end else if (do_product) begin
         prod_ff  <= RANK_PROD_W'(count_ff) * RANK_PROD_W'(level);
         shift_ff <= SCAN_W'(act);
         step_ff  <= '0;
      end else if (do_rank) begin
         rank_ff  <= rank_in;
         found_ff <= 1'b0;
         sel_ff   <= '0;
      end else if (do_select) begin
         shift_ff <= shift_ff >> DIGIT_W;
         step_ff  <= step_ff + STEP_W'(1);
         rank_ff  <= rank_step;
         found_ff <= found_in;
         sel_ff   <= sel_in;
      end
   end

   assign result.done       = (state_ff == SCN_DONE);
   assign result.note_valid = found_ff;
   assign result.sel        = sel_ff;
   assign result.count      = count_ff;

endmodule

`default_nettype wire

FILE: rtl/core/rank_select_scale_quantizer.sv
// ----------------------------------------------------------------------------
// rank_select_scale_quantizer
// Scale quantizer that keeps a mask of enabled tones, applies clear, random
// subset and toggle events, and picks the enabled tone whose rank follows a
// selection signal.
//
// One request word gives one response word. From acceptance to its response
// a word passes through the mask update and scan start, a count pass over the
// tone mask at two bits a clock, rank arithmetic, a select pass at two bits a
// clock that stops at the selected tone (none when there is no note), the close
// of the scan and the load of the response register. The next request is taken
// once the previous one has moved into the response register, so a response
// that waits does not hold up acceptance of the next word; the response of
// that word is loaded only once the waiting one is taken. Configuration
// registers must be written by the user through csr_we, csr_index and
// csr_wdata only while no word is in flight; the block does not enforce this.
// ----------------------------------------------------------------------------
`default_nettype none

module rank_select_scale_quantizer import rsq_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   rsq_req_if.sink               req_port,
   rsq_rsp_if.source             rsp_port
);

   ctl_state_type state_ff, state_in;

   logic [1:0]   range_mode_ff;
   logic         bipolar_ff;
   logic         subset_toggle_ff;
   req_word_type hold_ff;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic                      rsp_note_ff;
   logic signed [PITCH_W-1:0] rsp_pitch_ff;
   logic                      rsp_changed_ff;
   logic [ACTIVE_W-1:0]       rsp_active_ff;
   logic [FIN_W-1:0]          last_fin_ff;
   logic                      last_valid_ff;

   mask_cmd_type          cmd;
   scan_result_type       scan;
   logic [TONE_COUNT-1:0] tone_on, act;
   logic                  req_ready, scan_start, rsp_load, rsp_free;
   logic signed [SIGNAL_W:0] level_raw;
   logic [LEVEL_W-1:0]    level;
   logic [BASE_W-1:0]     base;
   logic [FIN_W-1:0]      fin;
   logic                  changed;
   logic [ACTIVE_W-1:0]   active;

   assign rsp_free = !rsp_valid_ff || rsp_port.ready;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         CTL_IDLE:   if (req_port.valid) state_in = CTL_EVENT;
         CTL_EVENT:  state_in = CTL_TOGGLE;
         CTL_TOGGLE: state_in = CTL_START;
         CTL_START:  state_in = CTL_SCAN;
         CTL_SCAN:   if (scan.done) state_in = CTL_RESULT;
         CTL_RESULT: if (rsp_free) state_in = CTL_IDLE;
         default:    state_in = CTL_IDLE;
      endcase
   end

   // controls
   always_comb begin
      req_ready     = 1'b0;
      scan_start    = 1'b0;
      rsp_load      = 1'b0;
      cmd.event_go  = 1'b0;
      cmd.toggle_go = 1'b0;
      unique case (state_ff)
         CTL_IDLE:   req_ready     = 1'b1;
         CTL_EVENT:  cmd.event_go  = 1'b1;
         CTL_TOGGLE: cmd.toggle_go = 1'b1;
         CTL_START:  scan_start    = 1'b1;
         CTL_SCAN:   ;
         CTL_RESULT: rsp_load      = rsp_free;
         default:    ;
      endcase
   end

   assign cmd.reset_event     = hold_ff.reset_event;
   assign cmd.random_event    = hold_ff.random_event;
   assign cmd.cv_toggle_event = hold_ff.cv_toggle_event;
   assign cmd.button_event    = hold_ff.button_event;

   rsq_mask_unit u_mask (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .subset_toggle (subset_toggle_ff),
      .coin_mask     (hold_ff.coin_mask),
      .tone_cv_mv    (hold_ff.tone_cv_mv),
      .button_index  (hold_ff.button_index),
      .tone_on       (tone_on)
   );

   assign act = tone_on & window_mask(range_mode_ff);

   // level in mV, offset when bipolar, clamped to 0..10000
   always_comb begin
      level_raw = (SIGNAL_W+1)'(hold_ff.signal_mv) +
                  (bipolar_ff ? (SIGNAL_W+1)'(BIPOLAR_OFS) : '0);
      if (level_raw < 0) level = '0;
      else if (level_raw > (SIGNAL_W+1)'(LEVEL_MAX)) level = LEVEL_W'(LEVEL_MAX);
      else level = LEVEL_W'(level_raw);
   end

   rsq_rank_scan u_scan (
      .clock            (clock),
      .reset            (reset),
      .start            (scan_start),
      .act              (act),
      .signal_connected (hold_ff.signal_connected),
      .level            (level),
      .result           (scan)
   );

   always_comb begin
      base    = (hold_ff.base_tone > BASE_W'(BASE_MAX)) ? BASE_W'(BASE_MAX)
                                                        : hold_ff.base_tone;
      fin     = FIN_W'(scan.sel) + FIN_W'(base);
      if (scan.note_valid != last_valid_ff) changed = 1'b1;
      else changed = scan.note_valid && (fin != last_fin_ff);
      active  = (COUNT_W'(scan.count) > COUNT_W'(ACTIVE_MAX)) ? ACTIVE_W'(ACTIVE_MAX)
                                                              : ACTIVE_W'(scan.count);
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) rsp_valid_in = 1'b1;
      else if (rsp_port.ready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= CTL_IDLE;
         range_mode_ff    <= RANGE_ALL;
         bipolar_ff       <= 1'b0;
         subset_toggle_ff <= 1'b0;
         rsp_valid_ff     <= 1'b0;
         last_fin_ff      <= FIN_W'(LAST_RESET);
         last_valid_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            unique case (csr_index_type'(csr_index))
               CSR_RANGE_MODE:    range_mode_ff    <= csr_wdata[1:0];
               CSR_BIPOLAR:       bipolar_ff       <= csr_wdata[0];
               CSR_SUBSET_TOGGLE: subset_toggle_ff <= csr_wdata[0];
               default:           ;
            endcase
         end
         if (rsp_load) begin
            last_valid_ff <= scan.note_valid;
            if (scan.note_valid) last_fin_ff <= fin;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_port.valid && req_ready) begin
         hold_ff.reset_event      <= req_port.reset_event;
         hold_ff.random_event     <= req_port.random_event;
         hold_ff.coin_mask        <= req_port.coin_mask;
         hold_ff.cv_toggle_event  <= req_port.cv_toggle_event;
         hold_ff.tone_cv_mv       <= req_port.tone_cv_mv;
         hold_ff.button_event     <= req_port.button_event;
         hold_ff.button_index     <= req_port.button_index;
         hold_ff.signal_connected <= req_port.signal_connected;
         hold_ff.signal_mv        <= req_port.signal_mv;
         hold_ff.base_tone        <= req_port.base_tone;
      end
      if (rsp_load) begin
         rsp_note_ff    <= scan.note_valid;
         rsp_pitch_ff   <= scan.note_valid ? PITCH_W'(fin - FIN_W'(TONE_OFS)) : '0;
         rsp_changed_ff <= changed;
         rsp_active_ff  <= active;
      end
   end

   assign req_port.ready           = req_ready;
   assign rsp_port.valid           = rsp_valid_ff;
   assign rsp_port.note_valid      = rsp_note_ff;
   assign rsp_port.pitch_semitones = rsp_pitch_ff;
   assign rsp_port.tone_changed    = rsp_changed_ff;
   assign rsp_port.active_count    = rsp_active_ff;

endmodule

`default_nettype wire
